// ===== hw/rtl/gcbg_pkg.sv =====
// Shared constants, types and codes for the glyph column bit gather block.
`default_nettype none

package gcbg_pkg;

  // Strike memory geometry
  localparam int MEM_BYTES  = 4096;
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int MAX_HEIGHT = 64;
  localparam int ROW_CW     = $clog2(MAX_HEIGHT);
  localparam int HT_W       = $clog2(MAX_HEIGHT + 1);

  // Field and register widths
  localparam int PH_W  = 7;
  localparam int RB_W  = 13;
  localparam int BB_W  = 12;
  localparam int OFF_W = 21;

  // Reset values of the configuration registers
  localparam logic [PH_W-1:0] PIXEL_HEIGHT_RST = 7'd16;
  localparam logic [RB_W-1:0] ROW_BYTES_RST    = 13'd64;
  localparam logic [BB_W-1:0] BITMAP_BASE_RST  = 12'd0;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_PIXEL_HEIGHT = 2'd0;
  localparam logic [1:0] REG_ROW_BYTES    = 2'd1;
  localparam logic [1:0] REG_BITMAP_BASE  = 2'd2;

  // Item operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [PH_W-1:0] pixel_height;
    logic [RB_W-1:0] row_bytes;
    logic [BB_W-1:0] bitmap_base;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              start;
    logic              issue;
    logic              last;
    logic [ROW_CW-1:0] row;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic can_issue;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/glyph_column_bit_gather.sv =====
// Extract rows pass the item registers, bank read and read-stage registers, then the output
// register. A load item leaves the input free; an extract item stalls it until its rows, up
// to 64, are read from two memory banks by the row sequencer, one a cycle unless out_stall.
// Reset: synchronous active-low rst_n clears the controller, the output register and
// restores the configuration registers; the strike memory is not cleared and is
// undefined until loaded.
`default_nettype none

module glyph_column_bit_gather (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [11:0] in_load_address,
  input  wire logic [7:0]  in_load_value,
  input  wire logic [15:0] in_glyph_pixel_offset,
  input  wire logic [15:0] in_glyph_width,
  input  wire logic [12:0] in_byte_column,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_column_byte,
  output logic [5:0]       out_row_index,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  gcbg_pkg::cfg_t       cfg;
  gcbg_pkg::ctrl_cmd_t  cmd;
  gcbg_pkg::dp_status_t stat;

  gcbg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gcbg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .cfg      (cfg),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcbg_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg                   (cfg),
    .in_load_address       (in_load_address),
    .in_load_value         (in_load_value),
    .in_glyph_pixel_offset (in_glyph_pixel_offset),
    .in_glyph_width        (in_glyph_width),
    .in_byte_column        (in_byte_column),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_column_byte       (out_column_byte),
    .out_row_index         (out_row_index),
    .out_last              (out_last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gcbg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gcbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gcbg_regs.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none

module gcbg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output gcbg_pkg::cfg_t     cfg
);

  gcbg_pkg::cfg_t cfg_r;
  gcbg_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Decode a write into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        gcbg_pkg::REG_PIXEL_HEIGHT: cfg_nxt.pixel_height = pwdata[gcbg_pkg::PH_W-1:0];
        gcbg_pkg::REG_ROW_BYTES:    cfg_nxt.row_bytes    = pwdata[gcbg_pkg::RB_W-1:0];
        gcbg_pkg::REG_BITMAP_BASE:  cfg_nxt.bitmap_base  = pwdata[gcbg_pkg::BB_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_height <= gcbg_pkg::PIXEL_HEIGHT_RST;
      cfg_r.row_bytes    <= gcbg_pkg::ROW_BYTES_RST;
      cfg_r.bitmap_base  <= gcbg_pkg::BITMAP_BASE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[3:2])
      gcbg_pkg::REG_PIXEL_HEIGHT: prdata = 32'(cfg_r.pixel_height);
      gcbg_pkg::REG_ROW_BYTES:    prdata = 32'(cfg_r.row_bytes);
      gcbg_pkg::REG_BITMAP_BASE:  prdata = 32'(cfg_r.bitmap_base);
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gcbg_ctrl.sv =====
// Controller: accepts items and sequences one strike read per row.
`default_nettype none

module gcbg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  output logic                     in_stall,
  input  wire gcbg_pkg::cfg_t      cfg,
  input  wire gcbg_pkg::dp_status_t stat,
  output gcbg_pkg::ctrl_cmd_t      cmd
);

  gcbg_pkg::state_t                state_r;
  gcbg_pkg::state_t                state_nxt;
  logic [gcbg_pkg::ROW_CW-1:0]     row_r;
  logic [gcbg_pkg::ROW_CW-1:0]     row_nxt;
  logic [gcbg_pkg::HT_W-1:0]       height_r;
  logic [gcbg_pkg::HT_W-1:0]       height_nxt;
  logic [gcbg_pkg::HT_W-1:0]       height_cfg;
  logic                            accept;
  logic                            start;
  logic                            last_row;

  // Saturate the configured height to the row capacity
  assign height_cfg = (32'(cfg.pixel_height) > gcbg_pkg::MAX_HEIGHT) ?
                      gcbg_pkg::HT_W'(gcbg_pkg::MAX_HEIGHT) :
                      gcbg_pkg::HT_W'(cfg.pixel_height);

  assign accept   = in_valid && !in_stall;
  assign start    = accept && (in_op == gcbg_pkg::OP_EXTRACT);
  assign last_row = (gcbg_pkg::HT_W'(row_r) + gcbg_pkg::HT_W'(1)) == height_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcbg_pkg::ST_IDLE: begin
        if (start && (height_cfg != '0)) begin
          state_nxt = gcbg_pkg::ST_RUN;
        end
      end
      gcbg_pkg::ST_RUN: begin
        if (stat.can_issue && last_row) begin
          state_nxt = gcbg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gcbg_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = 1'b0;
    cmd.load  = 1'b0;
    cmd.start = 1'b0;
    cmd.issue = 1'b0;
    cmd.last  = last_row;
    cmd.row   = row_r;
    case (state_r)
      gcbg_pkg::ST_IDLE: begin
        cmd.load  = accept && (in_op == gcbg_pkg::OP_LOAD);
        cmd.start = start;
      end
      gcbg_pkg::ST_RUN: begin
        in_stall  = 1'b1;
        cmd.issue = stat.can_issue;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Row counter and latched height
  always_comb begin
    row_nxt    = row_r;
    height_nxt = height_r;
    if (start) begin
      row_nxt    = '0;
      height_nxt = height_cfg;
    end else if (cmd.issue && !last_row) begin
      row_nxt = row_r + gcbg_pkg::ROW_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gcbg_pkg::ST_IDLE;
      row_r    <= '0;
      height_r <= '0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      height_r <= height_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gcbg_dp.sv =====
// Datapath: strike memory banks, row address generation and bit gathering.
`default_nettype none

module gcbg_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire gcbg_pkg::ctrl_cmd_t  cmd,
  output gcbg_pkg::dp_status_t      stat,
  input  wire gcbg_pkg::cfg_t       cfg,
  input  wire logic [11:0]          in_load_address,
  input  wire logic [7:0]           in_load_value,
  input  wire logic [15:0]          in_glyph_pixel_offset,
  input  wire logic [15:0]          in_glyph_width,
  input  wire logic [12:0]          in_byte_column,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [7:0]                out_column_byte,
  output logic [5:0]                out_row_index,
  output logic                      out_last
);

  localparam int OW = gcbg_pkg::OFF_W;
  localparam int AW = gcbg_pkg::MEM_AW;

  // Item registers
  logic [15:0]   s0_r;
  logic [7:0]    mask_r;
  logic [OW-1:0] limit_r;
  logic [OW-1:0] row_off_r;

  // Read-stage registers
  logic          pend_r;
  logic          pend_nxt;
  logic [2:0]    pk_r;
  logic [7:0]    pmask_r;
  logic          pv0_r;
  logic          pv1_r;
  logic [5:0]    prow_r;
  logic          plast_r;

  // Output registers
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic [5:0]    out_row_r;
  logic          out_last_r;

  logic [15:0]   x0;
  logic [15:0]   s0_in;
  logic [7:0]    mask_in;
  logic [12:0]   b0;
  logic [12:0]   b1;
  logic [OW-1:0] off0;
  logic [OW-1:0] off1;
  logic          v0;
  logic          v1;
  logic [AW-1:0] addr0;
  logic [AW-1:0] addr1;
  logic [AW-1:0] waddr;
  logic [7:0]    rd0;
  logic [7:0]    rd1;
  logic          move;
  logic [15:0]   word;
  logic [15:0]   shifted;
  logic [7:0]    gathered;

  // Item setup: first strike column and pixel mask
  assign x0    = {in_byte_column, 3'b000};
  assign s0_in = in_glyph_pixel_offset + x0;

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      mask_in[7-p] = (x0 + 16'(p)) < in_glyph_width;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      s0_r      <= s0_in;
      mask_r    <= mask_in;
      limit_r   <= OW'(cfg.row_bytes) * OW'(cfg.pixel_height);
      row_off_r <= '0;
    end else if (cmd.issue) begin
      row_off_r <= row_off_r + OW'(cfg.row_bytes);
    end
  end

  // Row addresses of the two bytes a column can straddle
  assign b0    = s0_r[15:3];
  assign b1    = b0 + 13'd1;
  assign off0  = row_off_r + OW'(b0);
  assign off1  = row_off_r + OW'(b1);
  assign v0    = off0 < limit_r;
  assign v1    = off1 < limit_r;
  assign addr0 = AW'(32'(cfg.bitmap_base) + 32'(off0));
  assign addr1 = AW'(32'(cfg.bitmap_base) + 32'(off1));
  assign waddr = AW'(in_load_address);

  // Two banks with identical contents, one per straddled byte
  gcbg_ram #(
    .WIDTH (8),
    .DEPTH (gcbg_pkg::MEM_BYTES)
  ) u_bank0 (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (waddr),
    .wdata (in_load_value),
    .re    (cmd.issue),
    .raddr (addr0),
    .rdata (rd0)
  );

  gcbg_ram #(
    .WIDTH (8),
    .DEPTH (gcbg_pkg::MEM_BYTES)
  ) u_bank1 (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (waddr),
    .wdata (in_load_value),
    .re    (cmd.issue),
    .raddr (addr1),
    .rdata (rd1)
  );

  // Advance the read stage into the output register when it is free
  assign move           = pend_r && (!out_valid_r || !out_stall);
  assign stat.can_issue = !pend_r || move;
  assign pend_nxt       = cmd.issue ? 1'b1 : (move ? 1'b0 : pend_r);
  assign out_valid_nxt  = move ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      pk_r    <= s0_r[2:0];
      pmask_r <= mask_r;
      pv0_r   <= v0;
      pv1_r   <= v1;
      prow_r  <= 6'(cmd.row);
      plast_r <= cmd.last;
    end
  end

  // Gather eight pixels: drop out-of-range bytes, align, mask past the width
  assign word     = {pv0_r ? rd0 : 8'd0, pv1_r ? rd1 : 8'd0};
  assign shifted  = word << pk_r;
  assign gathered = shifted[15:8] & pmask_r;

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r <= gathered;
      out_row_r  <= prow_r;
      out_last_r <= plast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column_byte = out_byte_r;
  assign out_row_index   = out_row_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gcbg_port_check.sv =====
// Port-level checks for the glyph column bit gather block, bound to the top level.
`default_nettype none

module gcbg_port_check (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_op,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_column_byte,
  input wire logic [5:0] out_row_index,
  input wire logic       out_last
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_column_byte) && $stable(out_row_index) && $stable(out_last))
    else $error("stalled result item changed");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A load item leaves the input free in the next cycle
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == gcbg_pkg::OP_LOAD) |=> !in_stall)
    else $error("input stalled after load item");

  // The input stalls only after an extract item is taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && (in_op == gcbg_pkg::OP_EXTRACT)))
    else $error("input stalled without an extract item");

endmodule

bind glyph_column_bit_gather gcbg_port_check u_port_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_column_byte (out_column_byte),
  .out_row_index   (out_row_index),
  .out_last        (out_last)
);

`default_nettype wire
